// ===== rtl/core/voi_wac_pkg.sv =====
// ----------------------------------------------------------------------------
// voi_wac_pkg: shared definitions for the VOI window auto check unit
// Sample format and register codes, field widths and the sample decode and
// rescale helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package voi_wac_pkg;

  localparam int unsigned DefaultFractionBits = 16;

  localparam int unsigned RawWidth     = 32;
  localparam int unsigned SampleWidth  = 33;
  localparam int unsigned SlopeWidth   = 32;
  localparam int unsigned ValueWidth   = 48;
  localparam int unsigned WidthOutBits = 47;
  localparam int unsigned ProdWidth    = SampleWidth + SlopeWidth;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 48;
  localparam int unsigned OutDataWidth = 192;
  localparam int unsigned OutUserWidth = 2;

  // Sample format codes
  localparam logic [2:0] FmtU8  = 3'd0;
  localparam logic [2:0] FmtS8  = 3'd1;
  localparam logic [2:0] FmtU16 = 3'd2;
  localparam logic [2:0] FmtS16 = 3'd3;
  localparam logic [2:0] FmtU32 = 3'd4;
  localparam logic [2:0] FmtS32 = 3'd5;

  // Configuration register indexes
  localparam logic [CfgAddrWidth-1:0] CfgSampleFormat     = 3'd0;
  localparam logic [CfgAddrWidth-1:0] CfgMultiComponent   = 3'd1;
  localparam logic [CfgAddrWidth-1:0] CfgRescaleSlope     = 3'd2;
  localparam logic [CfgAddrWidth-1:0] CfgRescaleIntercept = 3'd3;
  localparam logic [CfgAddrWidth-1:0] CfgWindowCenter     = 3'd4;
  localparam logic [CfgAddrWidth-1:0] CfgWindowWidth      = 3'd5;

  localparam logic [2:0] ResetSampleFormat = FmtU16;

  // Product clip at +/- 2^50 before the intercept is added
  localparam logic signed [ProdWidth-1:0] ProdClip  = 65'sh0_0004_0000_0000_0000;
  localparam logic signed [51:0]          ClipPos52 = 52'sh4_0000_0000_0000;
  localparam logic signed [51:0]          ClipNeg52 = 52'shC_0000_0000_0000;

  localparam logic signed [52:0] Value48Max = 53'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [52:0] Value48Min = 53'sh1F_8000_0000_0000;

  // Output width ceiling
  localparam logic [WidthOutBits-1:0] WidthOutMax = 47'h3FFF_FFFF_FFFF;
  localparam logic signed [48:0]      WidthCap49  = 49'sh0_3FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         sat;
  } rescale_t;

  // Read the low bits of a raw word in the given format
  function automatic logic signed [SampleWidth-1:0] decode_sample(
    input logic [2:0]          fmt,
    input logic [RawWidth-1:0] raw
  );
    logic signed [SampleWidth-1:0] v;
    case (fmt)
      FmtU8:   v = {25'd0, raw[7:0]};
      FmtS8:   v = {{25{raw[7]}}, raw[7:0]};
      FmtU16:  v = {17'd0, raw[15:0]};
      FmtS16:  v = {{17{raw[15]}}, raw[15:0]};
      FmtU32:  v = {1'b0, raw};
      FmtS32:  v = {raw[31], raw};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clip the product, add the intercept, saturate to 48 bits
  function automatic rescale_t rescale(
    input logic signed [ProdWidth-1:0]  prod,
    input logic signed [ValueWidth-1:0] icpt
  );
    logic signed [51:0] clip;
    logic signed [52:0] sum;
    rescale_t           r;
    if (prod > ProdClip) begin
      clip = ClipPos52;
    end else if (prod < -ProdClip) begin
      clip = ClipNeg52;
    end else begin
      clip = prod[51:0];
    end
    sum = 53'(clip) + 53'(icpt);
    if (sum > Value48Max) begin
      r.value = Value48Max[47:0];
      r.sat   = 1'b1;
    end else if (sum < Value48Min) begin
      r.value = Value48Min[47:0];
      r.sat   = 1'b1;
    end else begin
      r.value = sum[47:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/voi_window_auto_check_unit.sv =====
// ----------------------------------------------------------------------------
// voi_window_auto_check_unit: default display window from a frame's range
// Tracks min and max of the sample stream, rescales them at the frame's last
// beat and checks the configured window against the data range.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle, also across frame ends, while a last
//   beat finds room downstream. A last-sample beat's result passes the input
//   register, min/max, multiply, rescale, window prep, window decision and
//   output register, and waits there while the sink stalls.
// Each stage is an elastic register; only frame-end beats travel past min/max.
// Reset: valids and frame state clear, the configuration registers take their
//   defaults; the configuration channel is always ready.
`default_nettype none

module voi_window_auto_check_unit #(
  parameter int unsigned FractionBits = voi_wac_pkg::DefaultFractionBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [voi_wac_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [voi_wac_pkg::CfgDataWidth-1:0]   cfg_data_i,
  // sample stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [voi_wac_pkg::RawWidth-1:0]       s_axis_tdata,  // [31:0] raw_sample
  input  logic                                   s_axis_tlast,  // last_sample
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [47:0] scaled_min, [95:48] scaled_max, [143:96] window_center_out,
  // [190:144] window_width_out, [191] zero
  output logic [voi_wac_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // [0] window_replaced, [1] saturated
  output logic [voi_wac_pkg::OutUserWidth-1:0]   m_axis_tuser
);

  localparam logic signed [47:0] OneFx   = 48'sd1 <<< FractionBits;
  localparam logic signed [48:0] OneFx49 = 49'sd1 <<< FractionBits;
  localparam logic signed [47:0] Fx255   = 48'sd255 <<< FractionBits;
  localparam logic signed [47:0] Fx127   = 48'sd127 <<< FractionBits;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]         fmt_q;
  logic               multi_q;
  logic signed [31:0] slope_q;
  logic signed [47:0] icpt_q;
  logic signed [47:0] wc_in_q;
  logic signed [47:0] ww_in_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= voi_wac_pkg::ResetSampleFormat;
      multi_q <= 1'b0;
      slope_q <= 32'(OneFx);
      icpt_q  <= '0;
      wc_in_q <= '0;
      ww_in_q <= OneFx;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        voi_wac_pkg::CfgSampleFormat:     fmt_q   <= cfg_data_i[2:0];
        voi_wac_pkg::CfgMultiComponent:   multi_q <= cfg_data_i[0];
        voi_wac_pkg::CfgRescaleSlope:     slope_q <= cfg_data_i[31:0];
        voi_wac_pkg::CfgRescaleIntercept: icpt_q  <= cfg_data_i;
        voi_wac_pkg::CfgWindowCenter:     wc_in_q <= cfg_data_i;
        voi_wac_pkg::CfgWindowWidth:      ww_in_q <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain: every stage past the input register advances when its successor has room
  // --------------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, g_valid_q, f_valid_q;
  logic b_ready, c_ready, d_ready, e_ready, g_ready, f_ready;
  logic a_consume;

  assign f_ready = !f_valid_q || m_axis_tready;
  assign g_ready = !g_valid_q || f_ready;
  assign e_ready = !e_valid_q || g_ready;
  assign d_ready = !d_valid_q || e_ready;
  assign c_ready = !c_valid_q || d_ready;
  assign b_ready = !b_valid_q || c_ready;

  // Mid-frame beats fold into min/max at once; a last beat needs room downstream
  logic a_last_q;
  assign a_consume     = a_valid_q && (!a_last_q || b_ready);
  assign s_axis_tready = !a_valid_q || a_consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) a_valid_q <= s_axis_tvalid;
      if (b_ready)       b_valid_q <= a_valid_q && a_last_q;
      if (c_ready)       c_valid_q <= b_valid_q;
      if (d_ready)       d_valid_q <= c_valid_q;
      if (e_ready)       e_valid_q <= d_valid_q;
      if (g_ready)       g_valid_q <= e_valid_q;
      if (f_ready)       f_valid_q <= g_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic [31:0] a_raw_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_raw_q  <= s_axis_tdata;
      a_last_q <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Running min/max; the first beat of a frame overwrites both
  // --------------------------------------------------------------------------
  logic signed [32:0] sample_v;
  logic signed [32:0] run_min_q, run_max_q;
  logic signed [32:0] acc_min_d, acc_max_d;
  logic               started_q;

  assign sample_v = voi_wac_pkg::decode_sample(fmt_q, a_raw_q);

  always_comb begin
    if (!started_q) begin
      acc_min_d = sample_v;
      acc_max_d = sample_v;
    end else begin
      acc_min_d = (sample_v < run_min_q) ? sample_v : run_min_q;
      acc_max_d = (sample_v > run_max_q) ? sample_v : run_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= '0;
      run_max_q <= '0;
      started_q <= 1'b0;
    end else if (a_consume) begin
      run_min_q <= acc_min_d;
      run_max_q <= acc_max_d;
      started_q <= !a_last_q;
    end
  end

  // Frame extremes captured at the last beat
  logic signed [32:0] b_min_q, b_max_q;

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q && a_last_q) begin
      b_min_q <= acc_min_d;
      b_max_q <= acc_max_d;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply by slope
  // --------------------------------------------------------------------------
  logic signed [64:0] c_pmin_q, c_pmax_q;

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_pmin_q <= $signed(b_min_q) * $signed(slope_q);
      c_pmax_q <= $signed(b_max_q) * $signed(slope_q);
    end
  end

  // --------------------------------------------------------------------------
  // Clip, add intercept, saturate to 48 bits
  // --------------------------------------------------------------------------
  voi_wac_pkg::rescale_t r_min, r_max;
  logic signed [47:0]    d_smin_q, d_smax_q;
  logic                  d_sat_q;

  assign r_min = voi_wac_pkg::rescale(c_pmin_q, icpt_q);
  assign r_max = voi_wac_pkg::rescale(c_pmax_q, icpt_q);

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      d_smin_q <= r_min.value;
      d_smax_q <= r_max.value;
      d_sat_q  <= r_min.sat | r_max.sat;
    end
  end

  // --------------------------------------------------------------------------
  // Window prep: range, midpoint and doubled bounds (exact halves)
  // --------------------------------------------------------------------------
  logic signed [48:0] e_range_d, e_safe_d, e_sum_d;
  logic signed [49:0] wc2, lo2, hi2, min2, max2;
  logic signed [49:0] e_a2_d, e_b2_d;
  logic               e_gt_d, e_inval_d;

  always_comb begin
    e_range_d = 49'(d_smax_q) - 49'(d_smin_q);
    e_gt_d    = d_smax_q > d_smin_q;
    e_safe_d  = (e_range_d > OneFx49) ? e_range_d : OneFx49;
    e_sum_d   = 49'(d_smax_q) + 49'(d_smin_q);
    wc2       = 50'(wc_in_q) <<< 1;
    lo2       = wc2 - 50'(ww_in_q);
    hi2       = wc2 + 50'(ww_in_q);
    min2      = 50'(d_smin_q) <<< 1;
    max2      = 50'(d_smax_q) <<< 1;
    e_inval_d = (ww_in_q <= 48'sd0) || (hi2 <= min2) || (lo2 >= max2);
    e_a2_d    = (lo2 > min2) ? lo2 : min2;
    e_b2_d    = (hi2 < max2) ? hi2 : max2;
  end

  logic signed [47:0] e_smin_q, e_smax_q, e_mid_q;
  logic signed [48:0] e_range_q, e_safe_q;
  logic signed [49:0] e_a2_q, e_b2_q;
  logic               e_sat_q, e_gt_q, e_inval_q;

  always_ff @(posedge clk_i) begin
    if (e_ready && d_valid_q) begin
      e_smin_q  <= d_smin_q;
      e_smax_q  <= d_smax_q;
      e_sat_q   <= d_sat_q;
      e_mid_q   <= e_sum_d[48:1];  // floor of the half sum
      e_range_q <= e_range_d;
      e_safe_q  <= e_safe_d;
      e_a2_q    <= e_a2_d;
      e_b2_q    <= e_b2_d;
      e_gt_q    <= e_gt_d;
      e_inval_q <= e_inval_d;
    end
  end

  // --------------------------------------------------------------------------
  // Window decision: reject when coverage * 50 < range (doubled coverage * 25)
  // --------------------------------------------------------------------------
  logic signed [50:0] cov_s;
  logic [49:0]        cov_u;
  logic [55:0]        cov25;
  logic               cov_low;

  always_comb begin
    cov_s   = 51'(e_b2_q) - 51'(e_a2_q);
    cov_u   = cov_s[50] ? '0 : cov_s[49:0];
    cov25   = ({6'd0, cov_u} << 4) + ({6'd0, cov_u} << 3) + {6'd0, cov_u};
    cov_low = cov25 < {7'd0, e_safe_q};
  end

  logic signed [47:0] g_smin_q, g_smax_q, g_mid_q;
  logic signed [48:0] g_range_q;
  logic               g_sat_q, g_repl_q;

  always_ff @(posedge clk_i) begin
    if (g_ready && e_valid_q) begin
      g_smin_q  <= e_smin_q;
      g_smax_q  <= e_smax_q;
      g_sat_q   <= e_sat_q;
      g_mid_q   <= e_mid_q;
      g_range_q <= e_range_q;
      g_repl_q  <= e_gt_q && (e_inval_q || cov_low);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick the window, clamp width, apply the fixed window
  // --------------------------------------------------------------------------
  logic signed [48:0] ww_sel;
  logic signed [47:0] f_smin_d, f_smax_d, f_wc_d;
  logic [46:0]        f_ww_d;
  logic               f_repl_d, f_sat_d;

  always_comb begin
    ww_sel = g_repl_q ? g_range_q : 49'(ww_in_q);
    if (multi_q) begin
      f_smin_d = '0;
      f_smax_d = Fx255;
      f_wc_d   = Fx127;
      f_ww_d   = Fx255[46:0];
      f_repl_d = 1'b0;
      f_sat_d  = 1'b0;
    end else begin
      f_smin_d = g_smin_q;
      f_smax_d = g_smax_q;
      f_wc_d   = g_repl_q ? g_mid_q : wc_in_q;
      if (ww_sel < OneFx49) begin
        f_ww_d = OneFx[46:0];
      end else if (ww_sel > voi_wac_pkg::WidthCap49) begin
        f_ww_d = voi_wac_pkg::WidthOutMax;
      end else begin
        f_ww_d = ww_sel[46:0];
      end
      f_repl_d = g_repl_q;
      f_sat_d  = g_sat_q;
    end
  end

  logic signed [47:0] f_smin_q, f_smax_q, f_wc_q;
  logic [46:0]        f_ww_q;
  logic               f_repl_q, f_sat_q;

  always_ff @(posedge clk_i) begin
    if (f_ready && g_valid_q) begin
      f_smin_q <= f_smin_d;
      f_smax_q <= f_smax_d;
      f_wc_q   <= f_wc_d;
      f_ww_q   <= f_ww_d;
      f_repl_q <= f_repl_d;
      f_sat_q  <= f_sat_d;
    end
  end

  assign m_axis_tvalid = f_valid_q;
  assign m_axis_tdata  = {1'b0, f_ww_q, f_wc_q, f_smax_q, f_smin_q};
  assign m_axis_tuser  = {f_sat_q, f_repl_q};

endmodule

`default_nettype wire

// ===== rtl/core/voi_wac_checker.sv =====
// ----------------------------------------------------------------------------
// voi_wac_checker: port-level checks for the VOI window auto check unit
// Watches the result stream and checks window consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

module voi_wac_checker #(
  parameter int unsigned FractionBits = voi_wac_pkg::DefaultFractionBits
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [voi_wac_pkg::OutDataWidth-1:0] m_axis_tdata,
  input wire logic [voi_wac_pkg::OutUserWidth-1:0] m_axis_tuser
);

  localparam logic [46:0] OneFx47 = 47'd1 << FractionBits;

  logic signed [47:0] smin, smax, center;
  logic [46:0]        width;
  logic signed [48:0] ext_sum, center2;

  assign smin    = m_axis_tdata[47:0];
  assign smax    = m_axis_tdata[95:48];
  assign center  = m_axis_tdata[143:96];
  assign width   = m_axis_tdata[190:144];
  assign ext_sum = 49'(smin) + 49'(smax);
  assign center2 = 49'(center) <<< 1;

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Width never drops below 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> width >= OneFx47)
    else $error("window width below one");

  // A replaced window needs a non-empty data range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> smax > smin)
    else $error("window replaced on empty range");

  // A replaced centre is the floored midpoint of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (center2 == ext_sum) || (center2 == ext_sum - 49'sd1))
    else $error("replaced centre is not the range midpoint");

endmodule

bind voi_window_auto_check_unit voi_wac_checker #(
  .FractionBits(FractionBits)
) u_voi_wac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_voi_window_auto_check_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voi_window_auto_check_unit: self-checking bench for the window check unit
// Streams sample frames through the block under random source gaps and sink
// stalls, predicts each frame's min/max, rescale and window decision in SV,
// and compares every result beat field by field against that prediction.
// ----------------------------------------------------------------------------

module tb_voi_window_auto_check_unit;

  import voi_wac_pkg::*;

  localparam int unsigned FracBits = DefaultFractionBits;

  // Fixed-point landmarks of the prediction, all in 64-bit signed arithmetic
  localparam longint OneFx    = 64'sd1 <<< FracBits;
  localparam longint ProdLim  = 64'sd1 <<< 50;
  localparam longint Sat48Max = (64'sd1 <<< 47) - 1;
  localparam longint Sat48Min = -(64'sd1 <<< 47);
  localparam longint Width47  = (64'sd1 <<< 46) - 1;

  localparam int unsigned RandomSamples = 1950;

  // One result beat: the fields of m_axis_tdata and m_axis_tuser
  typedef struct packed {
    logic [ValueWidth-1:0]   scaled_min;
    logic [ValueWidth-1:0]   scaled_max;
    logic [ValueWidth-1:0]   center;
    logic [WidthOutBits-1:0] width;
    logic                    replaced;
    logic                    saturated;
  } window_result_t;

  typedef struct packed {
    longint value;
    bit     clipped;
  } scaled_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrWidth-1:0] cfg_addr_i  = CfgSampleFormat;
  logic [CfgDataWidth-1:0] cfg_data_i  = '0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [RawWidth-1:0]     s_axis_tdata  = '0;
  logic                    s_axis_tlast  = 1'b0;

  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [OutUserWidth-1:0] m_axis_tuser;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  voi_window_auto_check_unit #(
    .FractionBits(FracBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies and the running frame extremes
  // --------------------------------------------------------------------------
  logic [2:0] cfg_format;
  logic       cfg_multi;
  longint     cfg_slope;
  longint     cfg_icpt;
  longint     cfg_center;
  longint     cfg_width;

  longint     frame_lo;
  longint     frame_hi;
  bit         frame_open;

  window_result_t expected_windows[$];
  int unsigned    mismatches   = 0;
  int unsigned    samples_sent = 0;

  // Idle controls: when set, the matching side runs without gaps or stalls
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;

  function automatic void reset_shadow();
    cfg_format = ResetSampleFormat;
    cfg_multi  = 1'b0;
    cfg_slope  = OneFx;
    cfg_icpt   = 0;
    cfg_center = 0;
    cfg_width  = OneFx;
    frame_lo   = 0;
    frame_hi   = 0;
    frame_open = 1'b0;
  endfunction

  // Read the raw word in the current format; unsupported formats read as zero
  function automatic longint decode_raw(logic [RawWidth-1:0] raw);
    case (cfg_format)
      FmtU8:   return longint'(raw[7:0]);
      FmtS8:   return longint'(signed'(raw[7:0]));
      FmtU16:  return longint'(raw[15:0]);
      FmtS16:  return longint'(signed'(raw[15:0]));
      FmtU32:  return longint'(raw);
      FmtS32:  return longint'(signed'(raw));
      default: return 0;
    endcase
  endfunction

  // Multiply by the slope, clip the product to +/-2^50, add the intercept,
  // then saturate to the signed 48-bit range
  function automatic scaled_t rescale_extreme(longint x);
    scaled_t s;
    longint  p;
    p = x * cfg_slope;
    if (p > ProdLim) p = ProdLim;
    if (p < -ProdLim) p = -ProdLim;
    p = p + cfg_icpt;
    s.clipped = 1'b1;
    if (p > Sat48Max) begin
      s.value = Sat48Max;
    end else if (p < Sat48Min) begin
      s.value = Sat48Min;
    end else begin
      s.value   = p;
      s.clipped = 1'b0;
    end
    return s;
  endfunction

  // Window decision at a frame end
  function automatic window_result_t frame_window();
    window_result_t r;
    scaled_t        lo_s;
    scaled_t        hi_s;
    longint         lo, hi, wc, ww, span, span_floor;
    longint         lo2, hi2, min2, max2, a, b, cov2;
    bit             reject;
    bit             clipped;
    reject  = 1'b0;
    clipped = 1'b0;
    if (cfg_multi) begin
      lo = 0;
      hi = 255 * OneFx;
      wc = 127 * OneFx;
      ww = 255 * OneFx;
    end else begin
      lo_s    = rescale_extreme(frame_lo);
      hi_s    = rescale_extreme(frame_hi);
      lo      = lo_s.value;
      hi      = hi_s.value;
      clipped = lo_s.clipped | hi_s.clipped;
      wc      = cfg_center;
      ww      = cfg_width;
      // An inverted or empty range keeps the configured window as it is
      if (hi > lo) begin
        span       = hi - lo;
        span_floor = (span > OneFx) ? span : OneFx;
        lo2        = 2 * wc - ww;
        hi2        = 2 * wc + ww;
        min2       = 2 * lo;
        max2       = 2 * hi;
        reject     = (ww <= 0) || (hi2 <= min2) || (lo2 >= max2);
        if (!reject) begin
          // Coverage under 2% of the range: cov * 50 < range, on doubled bounds
          a    = (lo2 > min2) ? lo2 : min2;
          b    = (hi2 < max2) ? hi2 : max2;
          cov2 = b - a;
          if (cov2 < 0) cov2 = 0;
          if (cov2 * 25 < span_floor) reject = 1'b1;
        end
        if (reject) begin
          ww = span;
          wc = (hi + lo) >>> 1;  // floor of the midpoint
        end
      end
      if (ww < OneFx) ww = OneFx;
      if (ww > Width47) ww = Width47;
    end
    r.scaled_min = lo[ValueWidth-1:0];
    r.scaled_max = hi[ValueWidth-1:0];
    r.center     = wc[ValueWidth-1:0];
    r.width      = ww[WidthOutBits-1:0];
    r.replaced   = reject;
    r.saturated  = clipped;
    return r;
  endfunction

  // Fold one accepted sample into the frame; a frame end queues its window
  function automatic void track_sample(logic [RawWidth-1:0] raw, bit last);
    longint v;
    v = decode_raw(raw);
    if (!frame_open) begin
      frame_lo   = v;
      frame_hi   = v;
      frame_open = 1'b1;
    end else begin
      if (v < frame_lo) frame_lo = v;
      if (v > frame_hi) frame_hi = v;
    end
    if (last) begin
      frame_open = 1'b0;
      expected_windows.push_back(frame_window());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Present one sample beat and hold it until the block takes it. Valid stays
  // high afterwards so back-to-back beats need no toggle; drop it only when
  // a gap follows.
  task automatic send_sample(input logic [RawWidth-1:0] raw, input bit last);
    int unsigned gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_sample(raw, last);
    samples_sent++;
  endtask

  // Write one register; valid drops for a cycle after every beat
  task automatic write_reg(input logic [CfgAddrWidth-1:0] addr,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CfgSampleFormat:     cfg_format = data[2:0];
      CfgMultiComponent:   cfg_multi  = data[0];
      CfgRescaleSlope:     cfg_slope  = longint'(signed'(data[31:0]));
      CfgRescaleIntercept: cfg_icpt   = longint'(signed'(data[47:0]));
      CfgWindowCenter:     cfg_center = longint'(signed'(data[47:0]));
      CfgWindowWidth:      cfg_width  = longint'(signed'(data[47:0]));
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the source, wait out every pending window, then let the pipeline
  // settle past its latency so a register write cannot hit a beat in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Integer value n as Q.16
  function automatic logic [CfgDataWidth-1:0] fx(longint n);
    longint v;
    v = n <<< FracBits;
    return v[CfgDataWidth-1:0];
  endfunction

  // Signed value of random magnitude below 2^k, k itself random up to max_bits
  function automatic logic [CfgDataWidth-1:0] rand_scaled(int unsigned max_bits);
    logic [63:0] v;
    int unsigned k;
    k = $urandom_range(max_bits);
    v = {$urandom(), $urandom()};
    v = v & ((64'd1 << k) - 64'd1);
    if ($urandom_range(1)) v = -v;
    return v[CfgDataWidth-1:0];
  endfunction

  // 48-bit signed register value: extremes, zero, scaled or fully random
  function automatic logic [CfgDataWidth-1:0] rand_q48(int unsigned max_bits);
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 48'h7FFF_FFFF_FFFF;
    if (r == 1) return 48'h8000_0000_0000;
    if (r == 2) return '0;
    if (r == 3) return 48'({$urandom(), $urandom()});
    return rand_scaled(max_bits);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and sink stall pattern
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  window_result_t seen;
  window_result_t want;
  int unsigned    stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.scaled_min = m_axis_tdata[47:0];
        seen.scaled_max = m_axis_tdata[95:48];
        seen.center     = m_axis_tdata[143:96];
        seen.width      = m_axis_tdata[190:144];
        seen.replaced   = m_axis_tuser[0];
        seen.saturated  = m_axis_tuser[1];
        if (expected_windows.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual %h %h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_windows.pop_front();
          check_field("scaled_min", 64'(want.scaled_min), 64'(seen.scaled_min));
          check_field("scaled_max", 64'(want.scaled_max), 64'(seen.scaled_max));
          check_field("window_center_out", 64'(want.center), 64'(seen.center));
          check_field("window_width_out", 64'(want.width), 64'(seen.width));
          check_field("window_replaced", 64'(want.replaced), 64'(seen.replaced));
          check_field("saturated", 64'(want.saturated), 64'(seen.saturated));
        end
      end
      // Stall the sink now and then; short stalls are common, long ones rare
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!sink_steady && $urandom_range(99) < 20) begin
        m_axis_tready <= 1'b0;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(50, 10)
                                              : $urandom_range(3);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values: u16, unit slope, window 0 +/- 0.5
  task automatic test_reset_defaults();
    send_sample(32'h0000_1234, 1'b0);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'h0000_FFFF, 1'b1);
    // lone last sample: min and max are the same word
    send_sample(32'hABCD_8001, 1'b1);
  endtask

  // One lone sample per format; the word has every sign bit set, and the two
  // unsupported codes must read it as zero
  task automatic test_sample_formats();
    for (int f = 0; f < 8; f++) begin
      drain();
      write_reg(CfgSampleFormat, 48'(f));
      send_sample(32'h8000_8080, 1'b1);
    end
  endtask

  // Multi-component frames report the fixed 0..255 window
  task automatic test_multi_component();
    drain();
    write_reg(CfgMultiComponent, 48'd1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    drain();
    write_reg(CfgMultiComponent, 48'd0);
  endtask

  // Data 0..200.0 against windows that pass, fail and overflow
  task automatic window_frame(input logic [CfgDataWidth-1:0] center,
                              input logic [CfgDataWidth-1:0] width);
    drain();
    write_reg(CfgWindowCenter, center);
    write_reg(CfgWindowWidth, width);
    send_sample(32'd200, 1'b0);
    send_sample(32'd0, 1'b1);
  endtask

  task automatic test_window_decision();
    drain();
    write_reg(CfgSampleFormat, 48'(FmtU16));
    write_reg(CfgRescaleSlope, fx(1));
    write_reg(CfgRescaleIntercept, '0);
    window_frame(fx(100), fx(200));          // covers the data: kept
    window_frame(fx(100), '0);               // zero width
    window_frame(fx(100), fx(-5));           // negative width
    window_frame(fx(1000), fx(10));          // misses the data
    window_frame(fx(100), fx(3));            // coverage just under 2%
    window_frame(fx(100), fx(4));            // coverage exactly 2%: kept
    window_frame(fx(100), 48'h7FFF_FFFF_FFFF); // width beyond 47 bits
    // negative slope inverts the range: configured window stays
    drain();
    write_reg(CfgRescaleSlope, fx(-1));
    write_reg(CfgWindowWidth, '0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd900, 1'b1);
  endtask

  // Push the rescale into both rails
  task automatic test_saturation();
    drain();
    write_reg(CfgSampleFormat, 48'(FmtU32));
    write_reg(CfgRescaleSlope, 48'h0000_7FFF_FFFF);
    write_reg(CfgRescaleIntercept, 48'h7FFF_FFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(CfgRescaleSlope, 48'h0000_8000_0000);
    write_reg(CfgRescaleIntercept, 48'h8000_0000_0000);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
  endtask

  // Randomized phases: fresh registers, then whole frames with random content
  task automatic test_random_frames();
    int unsigned phase_len;
    int unsigned phase_count;
    int unsigned frame_len;
    int unsigned r;
    logic [RawWidth-1:0] base;
    bit narrow;
    while (samples_sent < RandomSamples) begin
      drain();
      r = $urandom_range(9);
      write_reg(CfgSampleFormat, (r < 9) ? 48'($urandom_range(5))
                                         : 48'($urandom_range(7, 6)));
      write_reg(CfgMultiComponent, 48'($urandom_range(9) == 0));
      r = $urandom_range(9);
      if (r < 3)       write_reg(CfgRescaleSlope, fx(1));
      else if (r == 3) write_reg(CfgRescaleSlope, 48'h0000_7FFF_FFFF);
      else if (r == 4) write_reg(CfgRescaleSlope, 48'h0000_8000_0000);
      else if (r == 5) write_reg(CfgRescaleSlope, 48'($urandom()));
      else             write_reg(CfgRescaleSlope, 48'(rand_scaled(31) & 48'hFFFF_FFFF));
      write_reg(CfgRescaleIntercept, rand_q48(47));
      write_reg(CfgWindowCenter, rand_q48(40));
      write_reg(CfgWindowWidth, rand_q48(40));
      source_steady = ($urandom_range(4) == 0);
      sink_steady   = ($urandom_range(4) == 0);
      phase_len     = $urandom_range(120, 20);
      phase_count   = 0;
      // always close the phase on a frame end
      while (phase_count < phase_len) begin
        r = $urandom_range(9);
        frame_len = (r < 7) ? $urandom_range(8, 1)
                  : (r < 9) ? $urandom_range(40, 9) : 1;
        narrow = ($urandom_range(3) == 0);
        base   = $urandom();
        for (int unsigned i = 0; i < frame_len; i++) begin
          send_sample(narrow ? base + $urandom_range(3) : $urandom(),
                      i == frame_len - 1);
        end
        phase_count += frame_len;
      end
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, directed tests, random phases, then the verdict
  // --------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_sample_formats();
    test_multi_component();
    test_window_decision();
    test_saturation();
    test_random_frames();

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[voi_window_auto_check_unit] OK");
    end else begin
      $display("[voi_window_auto_check_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[voi_window_auto_check_unit] ERROR");
    $finish;
  end

endmodule
